FILE: design/hfrs_pkg.sv
// Package for the Haar feature rectangle scaler: widths, constants and the
// word types that the pipeline modules pass between each other.
// No dependencies.
package hfrs_pkg;

	localparam int COORD_BITS      = 12;
	localparam int BASE_BITS       = 8;
	localparam int SCALE_FRAC_BITS = 8;
	localparam int SCALE_BITS      = 16;
	localparam int PROD_BITS       = BASE_BITS + SCALE_BITS;
	localparam int WIDE_BITS       = PROD_BITS + 1;
	localparam int MAX_RECTS       = 4;
	localparam int CNT_BITS        = $clog2(MAX_RECTS);
	localparam int APB_ADDR_BITS   = 3;
	localparam int APB_DATA_BITS   = 32;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [BASE_BITS-1:0]  base_t;

	localparam coord_t COORD_MAX = '1;
	localparam coord_t MIN_HALF  = coord_t'(2);
	localparam coord_t MIN_THIRD = coord_t'(3);
	localparam logic [SCALE_BITS-1:0] SCALE_ONE = SCALE_BITS'(1) << SCALE_FRAC_BITS;

	localparam logic [APB_ADDR_BITS-3:0] REG_SCALE = '0;

	typedef enum logic [2:0] {
		MASK_HALF_H  = 3'd0,
		MASK_HALF_V  = 3'd1,
		MASK_THIRD_H = 3'd2,
		MASK_THIRD_V = 3'd3,
		MASK_DIAG    = 3'd4
	} mask_type_t;

	typedef struct packed {
		logic [2:0] mask_type;
		base_t      feat_x;
		base_t      feat_y;
		base_t      feat_w;
		base_t      feat_h;
		coord_t     win_x;
		coord_t     win_y;
	} feature_t;

	typedef struct packed {
		coord_t loc_x;
		coord_t loc_y;
		coord_t rect_left;
		coord_t rect_top;
		coord_t rect_right;
		coord_t rect_bottom;
		logic   is_black;
		logic   last;
	} rect_t;

	typedef struct packed {
		mask_type_t mask_type;
		coord_t     loc_x;
		coord_t     loc_y;
		coord_t     width;
		coord_t     height;
	} geom_t;

	typedef struct packed {
		coord_t left;
		coord_t top;
		coord_t right;
		coord_t bottom;
		logic   is_black;
	} rect_box_t;

	typedef struct packed {
		coord_t                      loc_x;
		coord_t                      loc_y;
		rect_box_t [MAX_RECTS-1:0]   box;
		logic [CNT_BITS-1:0]         cnt_m1;
	} rect_list_t;

endpackage

FILE: design/haar_feature_rect_scaler.sv
// Top level of the Haar feature rectangle scaler: input register, scaling
// and rectangle stages, result sequencer and configuration port.
// Depends on hfrs_pkg, hfrs_cfg, hfrs_scale, hfrs_rects and hfrs_emit.

// A feature is taken when start is high and busy is low; its rectangles come
// out one word per cycle on rect, each marked by rect_valid for one cycle,
// white ones first, with last set on the final one. When the result port is
// idle, the first rectangle passes the input register, the scaled-feature
// register, the sequencer's list register and the result register. A feature
// of two-halves type gives two words, a thirds feature three and a diagonal
// feature four; the one-word-per-cycle result port sets the rate at which
// features are taken. An unknown pattern type is taken and gives no words.
// The receiver cannot stall the result port. Write the scale register only
// while no feature is in flight.
module haar_feature_rect_scaler import hfrs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	input  logic                     start,
	output logic                     busy,
	input  feature_t                 feature,
	output rect_t                    rect,
	output logic                     rect_valid
);

	logic [SCALE_BITS-1:0] scale;
	feature_t              feat_s1;
	logic                  valid_s1;
	geom_t                 geom;
	geom_t                 geom_s2;
	logic                  valid_s2;
	rect_list_t            list;
	logic                  emit_ready;
	logic                  free_s2;
	logic                  adv_s1;
	logic                  adv_s2;
	logic                  accept;

	assign free_s2 = !valid_s2 || emit_ready;
	assign adv_s2  = valid_s2 && emit_ready;
	assign adv_s1  = valid_s1 && free_s2;
	assign busy    = valid_s1 && !free_s2;
	assign accept  = start && !busy;

	hfrs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.scale   (scale)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= (feature.mask_type <= MASK_DIAG);
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			feat_s1 <= feature;
		end
		if (adv_s1) begin
			geom_s2 <= geom;
		end
	end

	hfrs_scale u_scale (
		.feat  (feat_s1),
		.scale (scale),
		.geom  (geom)
	);

	hfrs_rects u_rects (
		.geom (geom_s2),
		.list (list)
	);

	hfrs_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (adv_s2),
		.list       (list),
		.ready      (emit_ready),
		.rect       (rect),
		.rect_valid (rect_valid)
	);

	// A word that is not the last of its feature is followed at once by the
	// next word of the same feature.
	a_burst_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		rect_valid && !rect.last |=> rect_valid && $stable(rect.loc_x) && $stable(rect.loc_y))
		else $error("rectangle burst broken");

	// A stalled scaled feature keeps its contents.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !emit_ready |=> valid_s2 && $stable(geom_s2))
		else $error("stage two lost while stalled");

	// The input only stalls when the stages behind it are full.
	a_busy_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> valid_s1 && valid_s2)
		else $error("busy with room in the pipeline");

	// A word leaves only if the sequencer held a list in the previous cycle.
	a_word_source: assert property (@(posedge clk) disable iff (!arst_n)
		rect_valid |-> $past(u_emit.valid_s3))
		else $error("result word without a source");

endmodule

FILE: design/hfrs_cfg.sv
// Configuration register file of the rectangle scaler: the scale register
// behind an APB-style port. Depends on hfrs_pkg.
module hfrs_cfg import hfrs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	output logic [SCALE_BITS-1:0]    scale
);

	logic [SCALE_BITS-1:0] scale_q;
	logic                  hit_scale;

	assign hit_scale = (paddr[APB_ADDR_BITS-1:2] == REG_SCALE);
	assign pready    = 1'b1;
	assign scale     = scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_ONE;
		end else if (psel && penable && pwrite && pready && hit_scale) begin
			scale_q <= pwdata[SCALE_BITS-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit_scale) begin
			prdata = APB_DATA_BITS'(scale_q);
		end
	end

endmodule

FILE: design/hfrs_scale.sv
// Scaling stage of the rectangle scaler: scaled mask location and scaled,
// saturated and clamped feature size. Depends on hfrs_pkg.
module hfrs_scale import hfrs_pkg::*; (
	input  feature_t              feat,
	input  logic [SCALE_BITS-1:0] scale,
	output geom_t                 geom
);

	typedef logic [WIDE_BITS-1:0] wide_t;

	localparam wide_t HALF_LSB = wide_t'(1) << (SCALE_FRAC_BITS - 1);

	function automatic coord_t sat_coord(input wide_t v);
		coord_t r;
		r = (v > wide_t'(COORD_MAX)) ? COORD_MAX : v[COORD_BITS-1:0];
		return r;
	endfunction

	function automatic coord_t scaled_loc(input base_t base, input coord_t origin,
		input logic [SCALE_BITS-1:0] s);
		wide_t p;
		wide_t v;
		p = wide_t'(base) * wide_t'(s);
		v = (p >> SCALE_FRAC_BITS) + wide_t'(origin);
		return sat_coord(v);
	endfunction

	function automatic coord_t scaled_size(input base_t base, input coord_t min_size,
		input logic [SCALE_BITS-1:0] s);
		wide_t  p;
		coord_t r;
		p = wide_t'(base) * wide_t'(s) + HALF_LSB;
		r = sat_coord(p >> SCALE_FRAC_BITS);
		return (r < min_size) ? min_size : r;
	endfunction

	mask_type_t mtype;
	coord_t     min_size;

	always_comb begin
		mtype       = mask_type_t'(feat.mask_type);
		min_size    = (mtype == MASK_THIRD_H || mtype == MASK_THIRD_V) ? MIN_THIRD : MIN_HALF;
		geom.mask_type = mtype;
		geom.loc_x  = scaled_loc(feat.feat_x, feat.win_x, scale);
		geom.loc_y  = scaled_loc(feat.feat_y, feat.win_y, scale);
		geom.width  = scaled_size(feat.feat_w, min_size, scale);
		geom.height = scaled_size(feat.feat_h, min_size, scale);
	end

endmodule

FILE: design/hfrs_rects.sv
// Rectangle stage of the rectangle scaler: splits the scaled mask into its
// white and black rectangles. Depends on hfrs_pkg.
module hfrs_rects import hfrs_pkg::*; (
	input  geom_t      geom,
	output rect_list_t list
);

	localparam int DIV3_SHIFT = COORD_BITS + 1;
	localparam int RECIP_BITS = COORD_BITS + 1;
	localparam logic [RECIP_BITS-1:0] RECIP3 = RECIP_BITS'((2 ** DIV3_SHIFT) / 3 + 1);

	function automatic coord_t div3(input coord_t n);
		logic [COORD_BITS+RECIP_BITS-1:0] p;
		p = (COORD_BITS+RECIP_BITS)'(n) * (COORD_BITS+RECIP_BITS)'(RECIP3);
		return p[DIV3_SHIFT +: COORD_BITS];
	endfunction

	function automatic rect_box_t mk_box(input coord_t l, input coord_t t, input coord_t r,
		input coord_t b, input logic black);
		rect_box_t x;
		x.left     = l;
		x.top      = t;
		x.right    = r;
		x.bottom   = b;
		x.is_black = black;
		return x;
	endfunction

	coord_t     zero;
	coord_t     one;
	coord_t     half_w;
	coord_t     half_h;
	coord_t     w_m1;
	coord_t     h_m1;
	coord_t     n;
	coord_t     third;
	coord_t     third2;
	coord_t     n_m1;
	coord_t     lo_end;
	coord_t     hi_start;
	coord_t     bk_start;
	coord_t     bk_end;
	logic [1:0] rem;
	logic       ext;

	always_comb begin
		zero     = '0;
		one      = coord_t'(1);
		half_w   = geom.width >> 1;
		half_h   = geom.height >> 1;
		w_m1     = geom.width - one;
		h_m1     = geom.height - one;
		n        = (geom.mask_type == MASK_THIRD_H) ? geom.width : geom.height;
		third    = div3(n);
		third2   = third << 1;
		rem      = 2'(n - third2 - third);
		ext      = (rem == 2'd2);
		n_m1     = n - one;
		lo_end   = third - one + coord_t'(ext);
		hi_start = third2 + coord_t'(rem);
		bk_start = third + coord_t'(ext);
		bk_end   = third2 - one + coord_t'(rem);

		list.loc_x  = geom.loc_x;
		list.loc_y  = geom.loc_y;
		list.box    = '0;
		list.cnt_m1 = '0;
		case (geom.mask_type)
			MASK_HALF_H: begin
				list.box[0] = mk_box(half_w, zero, w_m1, h_m1, 1'b0);
				list.box[1] = mk_box(zero, zero, half_w - one, h_m1, 1'b1);
				list.cnt_m1 = CNT_BITS'(1);
			end
			MASK_HALF_V: begin
				list.box[0] = mk_box(zero, half_h, w_m1, h_m1, 1'b0);
				list.box[1] = mk_box(zero, zero, w_m1, half_h - one, 1'b1);
				list.cnt_m1 = CNT_BITS'(1);
			end
			MASK_THIRD_H: begin
				list.box[0] = mk_box(zero, zero, lo_end, h_m1, 1'b0);
				list.box[1] = mk_box(hi_start, zero, n_m1, h_m1, 1'b0);
				list.box[2] = mk_box(bk_start, zero, bk_end, h_m1, 1'b1);
				list.cnt_m1 = CNT_BITS'(2);
			end
			MASK_THIRD_V: begin
				list.box[0] = mk_box(zero, zero, w_m1, lo_end, 1'b0);
				list.box[1] = mk_box(zero, hi_start, w_m1, n_m1, 1'b0);
				list.box[2] = mk_box(zero, bk_start, w_m1, bk_end, 1'b1);
				list.cnt_m1 = CNT_BITS'(2);
			end
			MASK_DIAG: begin
				list.box[0] = mk_box(half_w, zero, w_m1, half_h - one, 1'b0);
				list.box[1] = mk_box(zero, half_h, half_w - one, h_m1, 1'b0);
				list.box[2] = mk_box(zero, zero, half_w - one, half_h - one, 1'b1);
				list.box[3] = mk_box(half_w, half_h, w_m1, h_m1, 1'b1);
				list.cnt_m1 = CNT_BITS'(3);
			end
			default: begin
				list.cnt_m1 = '0;
			end
		endcase
	end

endmodule

FILE: design/hfrs_emit.sv
// Result sequencer of the rectangle scaler: holds one rectangle list and
// sends its entries, one word per cycle, through the result register.
// Depends on hfrs_pkg.
module hfrs_emit import hfrs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  rect_list_t list,
	output logic       ready,
	output rect_t      rect,
	output logic       rect_valid
);

	rect_list_t          list_s3;
	logic                valid_s3;
	logic [CNT_BITS-1:0] idx_q;
	rect_t               rect_q;
	logic                rect_valid_q;
	logic                last_now;
	rect_t               cur;

	assign last_now   = (idx_q == list_s3.cnt_m1);
	assign ready      = !valid_s3 || last_now;
	assign rect       = rect_q;
	assign rect_valid = rect_valid_q;

	always_comb begin
		cur.loc_x       = list_s3.loc_x;
		cur.loc_y       = list_s3.loc_y;
		cur.rect_left   = list_s3.box[idx_q].left;
		cur.rect_top    = list_s3.box[idx_q].top;
		cur.rect_right  = list_s3.box[idx_q].right;
		cur.rect_bottom = list_s3.box[idx_q].bottom;
		cur.is_black    = list_s3.box[idx_q].is_black;
		cur.last        = last_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3     <= 1'b0;
			idx_q        <= '0;
			rect_valid_q <= 1'b0;
		end else begin
			rect_valid_q <= valid_s3;
			if (load) begin
				valid_s3 <= 1'b1;
				idx_q    <= '0;
			end else if (valid_s3 && last_now) begin
				valid_s3 <= 1'b0;
			end else if (valid_s3) begin
				idx_q <= idx_q + CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			list_s3 <= list;
		end
		rect_q <= cur;
	end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench for haar_feature_rect_scaler: random and directed features, an
// independent rectangle predictor and a per-field check of every result word.
// Depends on hfrs_pkg and the haar_feature_rect_scaler design files.
module tb_top;
	import hfrs_pkg::*;

	typedef longint unsigned u64_t;

	localparam logic [2:0] MASK_BAD_LO = 3'd5;
	localparam logic [2:0] MASK_BAD_HI = 3'd7;
	localparam logic [APB_ADDR_BITS-1:0] SCALE_ADDR = APB_ADDR_BITS'({REG_SCALE, 2'b00});

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr = '0;
	logic [APB_DATA_BITS-1:0] pwdata = '0;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;
	logic                     start = 1'b0;
	logic                     busy;
	feature_t                 feature = '0;
	rect_t                    rect;
	logic                     rect_valid;

	feature_t          features_pending[$];
	rect_t             rects_due[$];
	logic [SCALE_BITS-1:0] scale_now = SCALE_ONE;
	int                mismatches = 0;
	int                wait_left = 0;
	bit                no_idle = 1'b0;
	bit                hold_for_drain = 1'b0;

	haar_feature_rect_scaler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.start     (start),
		.busy      (busy),
		.feature   (feature),
		.rect      (rect),
		.rect_valid(rect_valid)
	);

	always #4 clk = ~clk;

	function automatic u64_t clamp_coord(u64_t v);
		return (v > u64_t'(COORD_MAX)) ? u64_t'(COORD_MAX) : v;
	endfunction

	function automatic u64_t scaled_span(u64_t base, u64_t min_span);
		u64_t r;
		r = (base * scale_now + (u64_t'(1) << (SCALE_FRAC_BITS - 1))) >> SCALE_FRAC_BITS;
		r = clamp_coord(r);
		return (r < min_span) ? min_span : r;
	endfunction

	function automatic rect_t make_rect(u64_t lx, u64_t ly, u64_t l, u64_t t, u64_t r,
			u64_t b, logic blk);
		rect_t o;
		o.loc_x       = coord_t'(lx);
		o.loc_y       = coord_t'(ly);
		o.rect_left   = coord_t'(l);
		o.rect_top    = coord_t'(t);
		o.rect_right  = coord_t'(r);
		o.rect_bottom = coord_t'(b);
		o.is_black    = blk;
		o.last        = 1'b0;
		return o;
	endfunction

	function automatic void predict_rects(feature_t f);
		rect_t box [4];
		int    cnt;
		u64_t  lx, ly, w, h, mn, n, t, d, e, mw, mh;
		cnt = 0;
		if (f.mask_type > MASK_DIAG)
			return;
		lx = clamp_coord(((u64_t'(f.feat_x) * scale_now) >> SCALE_FRAC_BITS) + u64_t'(f.win_x));
		ly = clamp_coord(((u64_t'(f.feat_y) * scale_now) >> SCALE_FRAC_BITS) + u64_t'(f.win_y));
		mn = (f.mask_type == MASK_THIRD_H || f.mask_type == MASK_THIRD_V) ?
			u64_t'(MIN_THIRD) : u64_t'(MIN_HALF);
		w = scaled_span(u64_t'(f.feat_w), mn);
		h = scaled_span(u64_t'(f.feat_h), mn);
		case (mask_type_t'(f.mask_type))
			MASK_HALF_H: begin
				box[0] = make_rect(lx, ly, w / 2, 0, w - 1, h - 1, 1'b0);
				box[1] = make_rect(lx, ly, 0, 0, w / 2 - 1, h - 1, 1'b1);
				cnt = 2;
			end
			MASK_HALF_V: begin
				box[0] = make_rect(lx, ly, 0, h / 2, w - 1, h - 1, 1'b0);
				box[1] = make_rect(lx, ly, 0, 0, w - 1, h / 2 - 1, 1'b1);
				cnt = 2;
			end
			MASK_THIRD_H, MASK_THIRD_V: begin
				n = (f.mask_type == MASK_THIRD_H) ? w : h;
				t = n / 3;
				d = n % 3;
				e = (d == 2) ? 1 : 0;
				if (f.mask_type == MASK_THIRD_H) begin
					box[0] = make_rect(lx, ly, 0, 0, t - 1 + e, h - 1, 1'b0);
					box[1] = make_rect(lx, ly, 2 * t + d, 0, n - 1, h - 1, 1'b0);
					box[2] = make_rect(lx, ly, t + e, 0, 2 * t - 1 + d, h - 1, 1'b1);
				end else begin
					box[0] = make_rect(lx, ly, 0, 0, w - 1, t - 1 + e, 1'b0);
					box[1] = make_rect(lx, ly, 0, 2 * t + d, w - 1, n - 1, 1'b0);
					box[2] = make_rect(lx, ly, 0, t + e, w - 1, 2 * t - 1 + d, 1'b1);
				end
				cnt = 3;
			end
			default: begin
				mw = w / 2;
				mh = h / 2;
				box[0] = make_rect(lx, ly, mw, 0, w - 1, mh - 1, 1'b0);
				box[1] = make_rect(lx, ly, 0, mh, mw - 1, h - 1, 1'b0);
				box[2] = make_rect(lx, ly, 0, 0, mw - 1, mh - 1, 1'b1);
				box[3] = make_rect(lx, ly, mw, mh, w - 1, h - 1, 1'b1);
				cnt = 4;
			end
		endcase
		box[cnt - 1].last = 1'b1;
		for (int i = 0; i < cnt; i++)
			rects_due.insert(rects_due.size(), box[i]);
	endfunction

	function automatic void check_field(string fname, u64_t want, u64_t got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
			mismatches++;
		end
	endfunction

	function automatic feature_t make_feature(logic [2:0] mt, base_t x, base_t y, base_t w,
			base_t h, coord_t wx, coord_t wy);
		feature_t f;
		f.mask_type = mt;
		f.feat_x    = x;
		f.feat_y    = y;
		f.feat_w    = w;
		f.feat_h    = h;
		f.win_x     = wx;
		f.win_y     = wy;
		return f;
	endfunction

	function automatic void queue_feature(feature_t f);
		features_pending.insert(features_pending.size(), f);
	endfunction

	function automatic base_t rand_span();
		return ($urandom_range(0, 9) < 7) ? base_t'($urandom_range(0, 40)) :
			base_t'($urandom_range(0, 255));
	endfunction

	function automatic feature_t rand_feature();
		logic [2:0] mt;
		if ($urandom_range(0, 9) == 0)
			mt = 3'($urandom_range(MASK_BAD_LO, MASK_BAD_HI));
		else
			mt = 3'($urandom_range(MASK_HALF_H, MASK_DIAG));
		return make_feature(mt, base_t'($urandom_range(0, 255)), base_t'($urandom_range(0, 255)),
			rand_span(), rand_span(), coord_t'($urandom_range(0, 4095)),
			coord_t'($urandom_range(0, 4095)));
	endfunction

	// Feature sender: presents pending words with a random gap between them, or back to back in the no-idle phases.
	always @(posedge clk or negedge arst_n) begin
		int       wl;
		logic     go;
		feature_t f;
		if (!arst_n) begin
			start     <= 1'b0;
			feature   <= '0;
			wait_left <= 0;
		end else begin
			wl = wait_left;
			go = start;
			f  = feature;
			if (start && !busy) begin
				go = 1'b0;
				wl = no_idle ? 0 : $urandom_range(0, 7);
				if (!no_idle && $urandom_range(0, 15) == 0)
					hold_for_drain = 1'b1;
			end
			if (!go) begin
				if (wl > 0) begin
					wl = wl - 1;
				end else if (hold_for_drain && rects_due.size() != 0) begin
					wl = 0;
				end else if (features_pending.size() != 0) begin
					f  = features_pending.pop_front();
					go = 1'b1;
					hold_for_drain = 1'b0;
				end
			end
			start     <= go;
			feature   <= f;
			wait_left <= wl;
		end
	end

	// Result checker; predictions are queued at the edge that takes a feature.
	always @(posedge clk) begin
		rect_t want;
		if (arst_n) begin
			if (rect_valid) begin
				if (rects_due.size() == 0) begin
					$display("%0t ns: unexpected word, expected none, actual %h", $time, rect);
					mismatches++;
				end else begin
					want = rects_due.pop_front();
					check_field("loc_x", u64_t'(want.loc_x), u64_t'(rect.loc_x));
					check_field("loc_y", u64_t'(want.loc_y), u64_t'(rect.loc_y));
					check_field("rect_left", u64_t'(want.rect_left), u64_t'(rect.rect_left));
					check_field("rect_top", u64_t'(want.rect_top), u64_t'(rect.rect_top));
					check_field("rect_right", u64_t'(want.rect_right),
						u64_t'(rect.rect_right));
					check_field("rect_bottom", u64_t'(want.rect_bottom),
						u64_t'(rect.rect_bottom));
					check_field("is_black", u64_t'(want.is_black), u64_t'(rect.is_black));
					check_field("last", u64_t'(want.last), u64_t'(rect.last));
				end
			end
			if (start && !busy)
				predict_rects(feature);
		end
	end

	task automatic settle();
		while (features_pending.size() != 0 || start || rects_due.size() != 0)
			@(negedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_scale(logic [APB_DATA_BITS-1:0] word);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= SCALE_ADDR;
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		scale_now = word[SCALE_BITS-1:0];
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[SCALE_BITS-1:0] !== scale_now) begin
			$display("%0t ns: scale readback mismatch, expected %0d, actual %0d", $time,
				scale_now, prdata[SCALE_BITS-1:0]);
			mismatches++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		logic [SCALE_BITS-1:0] scales [8];
		int                    valid;
		feature_t              f;
		scales = '{16'd0, 16'd1, 16'hFFFF, 16'd128, 16'd383, 16'($urandom), 16'd1024, SCALE_ONE};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (int mt = MASK_HALF_H; mt <= MASK_DIAG; mt++) begin
			queue_feature(make_feature(3'(mt), 0, 0, 0, 0, 0, 0));
			queue_feature(make_feature(3'(mt), 255, 255, 255, 255, 4095, 4095));
		end
		queue_feature(make_feature(MASK_THIRD_H, 3, 4, 4, 6, 100, 200));
		queue_feature(make_feature(MASK_THIRD_H, 7, 1, 5, 3, 0, 4000));
		queue_feature(make_feature(MASK_THIRD_V, 2, 9, 6, 4, 50, 60));
		queue_feature(make_feature(MASK_THIRD_V, 0, 8, 3, 5, 4090, 10));
		queue_feature(make_feature(MASK_HALF_H, 1, 2, 7, 3, 5, 6));
		queue_feature(make_feature(MASK_HALF_V, 3, 4, 4, 9, 7, 8));
		queue_feature(make_feature(MASK_DIAG, 5, 6, 5, 7, 9, 10));
		queue_feature(make_feature(MASK_BAD_LO, 1, 1, 4, 4, 1, 1));
		queue_feature(make_feature(MASK_BAD_HI, 2, 2, 6, 6, 2, 2));

		for (int p = 0; p < 8; p++) begin
			settle();
			write_scale({(p % 2 == 1) ? 16'($urandom) : 16'h0000, scales[p]});
			no_idle = (p == 2 || p == 5);
			valid = 0;
			while (valid < 37) begin
				f = rand_feature();
				if (f.mask_type <= MASK_DIAG)
					valid++;
				queue_feature(f);
			end
		end
		settle();
		repeat (20) @(posedge clk);
		if (rects_due.size() != 0) begin
			$display("%0t ns: %0d words still expected at the end", $time, rects_due.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("PASS haar_feature_rect_scaler");
		else
			$display("FAIL haar_feature_rect_scaler");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL haar_feature_rect_scaler");
		$finish;
	end

endmodule
